// ===== rtl/nhe_pkg.sv =====
// Shared types, widths and fixed-point helpers for the neo-Hookean energy and stress unit.
// Depends on nothing; every other file imports it.
package nhe_pkg;

	localparam int FW = 32;   // input element width, Q16.16
	localparam int OW = 48;   // output width, Q32.16
	localparam int CW = 31;   // material register width
	localparam int AW = 130;  // wide accumulator width
	localparam int NE = 9;    // elements per matrix

	typedef logic signed [FW-1:0] fix_t;
	typedef logic signed [OW-1:0] out_t;
	typedef logic signed [63:0]   w64_t;
	typedef logic signed [AW-1:0] acc_t;
	typedef logic [CW-1:0]        coef_t;

	typedef enum logic [1:0] {
		REG_MU     = 2'd0,
		REG_LAMBDA = 2'd1,
		REG_ALPHA  = 2'd2
	} reg_idx_t;

	// round half up, then arithmetic shift right by n
	function automatic acc_t rnd(acc_t x, int n);
		acc_t half;
		half = acc_t'(1) <<< (n - 1);
		return (x + half) >>> n;
	endfunction

	// clamp to the signed 64-bit range
	function automatic w64_t sat64(acc_t x);
		if ((&x[AW-1:63]) || !(|x[AW-1:63])) begin
			return x[63:0];
		end
		return x[AW-1] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
	endfunction

	// clamp to the signed 48-bit range
	function automatic out_t sat48(acc_t x);
		if ((&x[AW-1:OW-1]) || !(|x[AW-1:OW-1])) begin
			return x[OW-1:0];
		end
		return x[AW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
	endfunction

endpackage

// ===== rtl/nhe_lane.sv =====
// One element lane: cofactor, square and final stress term for one entry of F.
// Depends on nhe_pkg; the merge stage supplies the volume term g.
module nhe_lane (
	input  logic          clk,
	input  logic          en,
	input  nhe_pkg::fix_t fa,
	input  nhe_pkg::fix_t fb,
	input  nhe_pkg::fix_t fc,
	input  nhe_pkg::fix_t fd,
	input  nhe_pkg::fix_t fs,
	input  nhe_pkg::coef_t mu,
	input  nhe_pkg::w64_t g_s9,
	output nhe_pkg::out_t cof_s3,
	output nhe_pkg::w64_t sq_s3,
	output nhe_pkg::fix_t fs_s3,
	output nhe_pkg::out_t p_s11
);
	import nhe_pkg::*;

	w64_t p1_s2, p2_s2, sq_s2;
	fix_t fs_s2;
	out_t cof_dly_q [6];
	fix_t f_dly_q [6];
	logic signed [63:0] pm_s10;
	logic signed [57:0] q0_s10, q1_s10, q2_s10, q3_s10;
	logic signed [31:0] gh;
	logic signed [32:0] gl;
	logic signed [23:0] ch;
	logic signed [24:0] cl;
	acc_t sum;

	// form the two cross products and the square
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2 <= 64'(fa) * 64'(fb);
			p2_s2 <= 64'(fc) * 64'(fd);
			sq_s2 <= 64'(fs) * 64'(fs);
			fs_s2 <= fs;
		end
	end

	// round and clamp the cofactor
	always_ff @(posedge clk) begin
		if (en) begin
			cof_s3 <= sat48(rnd(acc_t'(p1_s2) - acc_t'(p2_s2), 16));
			sq_s3  <= sq_s2;
			fs_s3  <= fs_s2;
		end
	end

	// hold cofactor and element until g is ready
	always_ff @(posedge clk) begin
		if (en) begin
			cof_dly_q[0] <= cof_s3;
			f_dly_q[0]   <= fs_s3;
			for (int i = 1; i < 6; i++) begin
				cof_dly_q[i] <= cof_dly_q[i-1];
				f_dly_q[i]   <= f_dly_q[i-1];
			end
		end
	end

	assign gh = g_s9[63:32];
	assign gl = $signed({1'b0, g_s9[31:0]});
	assign ch = cof_dly_q[5][47:24];
	assign cl = $signed({1'b0, cof_dly_q[5][23:0]});

	// partial products of mu*F and g*cof
	always_ff @(posedge clk) begin
		if (en) begin
			pm_s10 <= 64'($signed({1'b0, mu})) * 64'(f_dly_q[5]);
			q0_s10 <= 58'(gh) * 58'(ch);
			q1_s10 <= 58'(gh) * 58'(cl);
			q2_s10 <= 58'(gl) * 58'(ch);
			q3_s10 <= 58'(gl) * 58'(cl);
		end
	end

	assign sum = acc_t'(pm_s10) + (acc_t'(q0_s10) <<< 56) + (acc_t'(q1_s10) <<< 32)
		+ (acc_t'(q2_s10) <<< 24) + acc_t'(q3_s10);

	// combine, round and clamp the stress entry
	always_ff @(posedge clk) begin
		if (en) begin
			p_s11 <= sat48(rnd(sum, 16));
		end
	end

endmodule

// ===== rtl/nhe_merge.sv =====
// Merge stage: determinant, squared norm, volume term g and energy from the lane results.
// Depends on nhe_pkg; fed by the nine nhe_lane instances.
module nhe_merge (
	input  logic          clk,
	input  logic          en,
	input  nhe_pkg::fix_t f0_s3 [3],
	input  nhe_pkg::out_t cof0_s3 [3],
	input  nhe_pkg::w64_t sq_s3 [nhe_pkg::NE],
	input  nhe_pkg::coef_t mu,
	input  nhe_pkg::coef_t lambda,
	input  nhe_pkg::coef_t alpha,
	output nhe_pkg::w64_t g_s9,
	output nhe_pkg::out_t energy_s11
);
	import nhe_pkg::*;

	logic signed [55:0] jh_s4 [3];
	logic signed [56:0] jl_s4 [3];
	logic signed [65:0] sqp_s4 [3];
	acc_t jsum_s5;
	w64_t t_s5, t_s6, t_s7, t_s8, t_s9;
	w64_t j_s6, d_s7, d_s8, d_s9;
	logic signed [64:0] lh_s8, ll_s8;
	logic signed [65:0] mth_s10, mtl_s10, hh_s10, hl_s10, lh_s10, ll_s10;
	acc_t jacc, tacc, lacc, eacc;
	logic signed [32:0] mu_s, lam_s;

	assign mu_s  = $signed({2'b00, mu});
	assign lam_s = $signed({2'b00, lambda});

	// partial products for det F and partial sums of squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				jh_s4[r]  <= 56'(f0_s3[r]) * 56'($signed(cof0_s3[r][47:24]));
				jl_s4[r]  <= 57'(f0_s3[r]) * 57'($signed({1'b0, cof0_s3[r][23:0]}));
				sqp_s4[r] <= 66'(sq_s3[3*r]) + 66'(sq_s3[3*r+1]) + 66'(sq_s3[3*r+2]);
			end
		end
	end

	always_comb begin
		jacc = '0;
		tacc = -(acc_t'(3) <<< 32);
		for (int r = 0; r < 3; r++) begin
			jacc = jacc + (acc_t'(jh_s4[r]) <<< 24) + acc_t'(jl_s4[r]);
			tacc = tacc + acc_t'(sqp_s4[r]);
		end
	end

	// sum det terms, finish the norm term
	always_ff @(posedge clk) begin
		if (en) begin
			jsum_s5 <= jacc;
			t_s5    <= sat64(rnd(tacc, 16));
		end
	end

	assign lacc = (acc_t'(lh_s8) <<< 32) + acc_t'(ll_s8);

	// det F, offset, volume term
	always_ff @(posedge clk) begin
		if (en) begin
			j_s6  <= sat64(rnd(jsum_s5, 16));
			t_s6  <= t_s5;
			d_s7  <= sat64(acc_t'(j_s6) - acc_t'($signed({1'b0, alpha})));
			t_s7  <= t_s6;
			lh_s8 <= 65'(lam_s) * 65'($signed(d_s7[63:32]));
			ll_s8 <= 65'(lam_s) * 65'($signed({1'b0, d_s7[31:0]}));
			d_s8  <= d_s7;
			t_s8  <= t_s7;
			g_s9  <= sat64(rnd(lacc, 16));
			d_s9  <= d_s8;
			t_s9  <= t_s8;
		end
	end

	// energy partial products mu*t and g*d
	always_ff @(posedge clk) begin
		if (en) begin
			mth_s10 <= 66'(mu_s) * 66'($signed(t_s9[63:32]));
			mtl_s10 <= 66'(mu_s) * 66'($signed({1'b0, t_s9[31:0]}));
			hh_s10  <= 66'($signed(g_s9[63:32])) * 66'($signed(d_s9[63:32]));
			hl_s10  <= 66'($signed(g_s9[63:32])) * 66'($signed({1'b0, d_s9[31:0]}));
			lh_s10  <= 66'($signed({1'b0, g_s9[31:0]})) * 66'($signed(d_s9[63:32]));
			ll_s10  <= 66'($signed({1'b0, g_s9[31:0]})) * 66'($signed({1'b0, d_s9[31:0]}));
		end
	end

	assign eacc = (acc_t'(mth_s10) <<< 32) + acc_t'(mtl_s10) + (acc_t'(hh_s10) <<< 64)
		+ (acc_t'(hl_s10) <<< 32) + (acc_t'(lh_s10) <<< 32) + acc_t'(ll_s10);

	// halve, round and clamp the energy
	always_ff @(posedge clk) begin
		if (en) begin
			energy_s11 <= sat48(rnd(eacc, 17));
		end
	end

endmodule

// ===== rtl/neo_hookean_energy_and_stress_unit.sv =====
// Neo-Hookean energy and first Piola-Kirchhoff stress for one 3x3 matrix per item.
// Pipeline: input register s1, stages s2 to s11 (cofactor, determinant, volume term, 64-bit
// split products), then the output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: asynchronous active low; clears valid flags, restores mu 1.0, lambda 2.0, alpha 1.5.
// Depends on nhe_pkg, nhe_lane and nhe_merge.
module neo_hookean_energy_and_stress_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// f_r0c0, f_r0c1, f_r0c2, f_r1c0, f_r1c1, f_r1c2, f_r2c0, f_r2c1, f_r2c2
	input  logic [287:0]        s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// energy, p_r0c0, p_r0c1, p_r0c2, p_r1c0, p_r1c1, p_r1c2, p_r2c0, p_r2c1, p_r2c2
	output logic [479:0]        m_tdata,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  nhe_pkg::coef_t      cfg_data
);
	import nhe_pkg::*;

	logic  en;
	logic  [11:1] vld_q;
	coef_t mu_q, lambda_q, alpha_q;
	fix_t  f_s1 [NE];
	out_t  cof_s3 [NE];
	w64_t  sq_s3 [NE];
	fix_t  fs_s3 [NE];
	out_t  p_s11 [NE];
	fix_t  f0_s3 [3];
	out_t  cof0_s3 [3];
	w64_t  g_s9;
	out_t  energy_s11;

	// advance everything unless a result is stuck at the output
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// material registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q     <= 31'd65536;
			lambda_q <= 31'd131072;
			alpha_q  <= 31'd98304;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MU:     mu_q     <= cfg_data;
				REG_LAMBDA: lambda_q <= cfg_data;
				REG_ALPHA:  alpha_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// valid flags follow the items through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q    <= {vld_q[10:1], s_tvalid};
			m_tvalid <= vld_q[11];
		end
	end

	// capture the input item
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NE; i++) begin
				f_s1[i] <= s_tdata[i*FW +: FW];
			end
		end
	end

	// one lane per element of F
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			localparam int R1 = (r + 1) % 3;
			localparam int R2 = (r + 2) % 3;
			localparam int C1 = (c + 1) % 3;
			localparam int C2 = (c + 2) % 3;
			nhe_lane u_lane (
				.clk    (clk),
				.en     (en),
				.fa     (f_s1[R1*3+C1]),
				.fb     (f_s1[R2*3+C2]),
				.fc     (f_s1[R2*3+C1]),
				.fd     (f_s1[R1*3+C2]),
				.fs     (f_s1[r*3+c]),
				.mu     (mu_q),
				.g_s9   (g_s9),
				.cof_s3 (cof_s3[r*3+c]),
				.sq_s3  (sq_s3[r*3+c]),
				.fs_s3  (fs_s3[r*3+c]),
				.p_s11  (p_s11[r*3+c])
			);
		end
		assign f0_s3[r]   = fs_s3[r*3];
		assign cof0_s3[r] = cof_s3[r*3];
	end

	nhe_merge u_merge (
		.clk        (clk),
		.en         (en),
		.f0_s3      (f0_s3),
		.cof0_s3    (cof0_s3),
		.sq_s3      (sq_s3),
		.mu         (mu_q),
		.lambda     (lambda_q),
		.alpha      (alpha_q),
		.g_s9       (g_s9),
		.energy_s11 (energy_s11)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata[OW-1:0] <= energy_s11;
			for (int i = 0; i < NE; i++) begin
				m_tdata[(i+1)*OW +: OW] <= p_s11[i];
			end
		end
	end

`ifndef ASSERT_OFF
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[1])
		else $error("accepted item did not enter the pipeline");
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[11] && en |=> m_tvalid)
		else $error("finished item lost before the output register");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during a stall");
`endif

endmodule

// ===== test/nhe_checker.sv =====
// Checker for the neo-Hookean energy and stress unit: watches both streams,
// predicts each result from the accepted matrix and compares field by field.
// Depends on nhe_pkg.
`timescale 1ns / 100ps

module nhe_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [287:0]        s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [479:0]        m_tdata,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  nhe_pkg::coef_t      cfg_data,
	output int                  fail_count,
	output int                  pending
);
	import nhe_pkg::*;

	typedef logic signed [159:0] big_t;

	localparam big_t MAX64 = big_t'(64'sh7FFF_FFFF_FFFF_FFFF);
	localparam big_t MIN64 = -MAX64 - 1;
	localparam big_t MAX48 = big_t'(48'sh7FFF_FFFF_FFFF);
	localparam big_t MIN48 = -MAX48 - 1;

	logic [30:0] shear, bulk, offset;
	logic [479:0] stress_queue[$];

	function automatic big_t half_up(big_t x, int n);
		return (x + (big_t'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic big_t clip(big_t x, big_t lo, big_t hi);
		if (x > hi) return hi;
		if (x < lo) return lo;
		return x;
	endfunction

	// Work out energy and stress for one matrix at the current moduli
	function automatic logic [479:0] material_response(logic [287:0] d);
		big_t f[3][3];
		big_t cf[3][3];
		big_t acc, jac, dv, gv, tv, mu_b;
		logic [479:0] res;
		mu_b = big_t'({1'b0, shear});
		for (int i = 0; i < 9; i++) f[i/3][i%3] = big_t'($signed(d[i*32 +: 32]));
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				acc = f[(r+1)%3][(c+1)%3] * f[(r+2)%3][(c+2)%3]
					- f[(r+2)%3][(c+1)%3] * f[(r+1)%3][(c+2)%3];
				cf[r][c] = clip(half_up(acc, 16), MIN48, MAX48);
			end
		acc = 0;
		for (int r = 0; r < 3; r++) acc += f[r][0] * cf[r][0];
		jac = clip(half_up(acc, 16), MIN64, MAX64);
		dv = clip(jac - big_t'({1'b0, offset}), MIN64, MAX64);
		gv = clip(half_up(big_t'({1'b0, bulk}) * dv, 16), MIN64, MAX64);
		acc = -(big_t'(3) <<< 32);
		for (int i = 0; i < 9; i++) acc += f[i/3][i%3] * f[i/3][i%3];
		tv = clip(half_up(acc, 16), MIN64, MAX64);
		acc = clip(half_up(mu_b * tv + gv * dv, 17), MIN64, MAX64);
		res[47:0] = 48'(clip(acc, MIN48, MAX48));
		for (int i = 0; i < 9; i++) begin
			acc = mu_b * f[i/3][i%3] + gv * cf[i/3][i%3];
			acc = clip(half_up(acc, 16), MIN64, MAX64);
			res[(i+1)*48 +: 48] = 48'(clip(acc, MIN48, MAX48));
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		fail_count++;
	endtask

	assign pending = stress_queue.size();

	// Track moduli, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		logic [479:0] want;
		if (!arst_n) begin
			shear = 31'd65536;
			bulk = 31'd131072;
			offset = 31'd98304;
			stress_queue.delete();
			fail_count = 0;
		end else begin
			if (s_tvalid && s_tready) stress_queue.push_back(material_response(s_tdata));
			if (m_tvalid && m_tready) begin
				if (stress_queue.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[47:0], '0);
				end else begin
					want = stress_queue.pop_front();
					for (int i = 0; i < 10; i++)
						if (m_tdata[i*48 +: 48] !== want[i*48 +: 48])
							report_mismatch(i == 0 ? "energy" : $sformatf("p[%0d]", i - 1),
								m_tdata[i*48 +: 48], want[i*48 +: 48]);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MU:     shear = cfg_data;
					REG_LAMBDA: bulk = cfg_data;
					REG_ALPHA:  offset = cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== test/neo_hookean_energy_and_stress_unit_tb.sv =====
// Testbench top for the neo-Hookean energy and stress unit: clock, reset,
// register phases, matrix stimulus and verdict. Depends on nhe_pkg and nhe_checker.
`timescale 1ns / 100ps

module neo_hookean_energy_and_stress_unit_tb;
	import nhe_pkg::*;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [287:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [479:0] m_tdata;
	logic         cfg_we = 0;
	logic [1:0]   cfg_index = REG_MU;
	coef_t        cfg_data = '0;
	int           fail_count, pending;
	int           cycles = 0;
	bit           no_idle = 0;
	bit           hold_off = 0;

	neo_hookean_energy_and_stress_unit i_dut (.*);
	nhe_checker i_chk (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("neo_hookean_energy_and_stress_unit_tb: done, errors");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off
	always @(posedge clk) begin
		if (hold_off) m_tready <= 0;
		else m_tready <= no_idle || ($urandom_range(99) >= 34);
	end

	function automatic logic [31:0] pick_elem(int mode);
		case (mode)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			3: return $urandom_range(0, 1) ? 32'($urandom_range(0, 196608)) :
				-32'($urandom_range(0, 196608));
			default: return 32'h0001_0000 + 32'($urandom_range(0, 16383)) - 32'd8192;
		endcase
	endfunction

	// Offer one item; drop tvalid only while idling
	task automatic send_matrix(logic [287:0] d);
		while (!no_idle && $urandom_range(99) < 34) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(int mode_hi);
		logic [287:0] d;
		for (int i = 0; i < 9; i++) begin
			if (mode_hi == 4 && i % 4 != 0) d[i*32 +: 32] = pick_elem(3) >>> 3;
			else d[i*32 +: 32] = pick_elem($urandom_range(mode_hi > 4 ? 2 : 0, mode_hi));
		end
		send_matrix(d);
	endtask

	task automatic write_reg(reg_idx_t idx, coef_t v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	// Stop offering and wait until every item has come out
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_moduli(coef_t a, coef_t b, coef_t c);
		drain();
		write_reg(REG_MU, a);
		write_reg(REG_LAMBDA, b);
		write_reg(REG_ALPHA, c);
		cfg_we <= 0;
	endtask

	initial begin
		logic [287:0] d;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: zero, identity, extremes, checkerboards
		send_matrix('0);
		send_matrix({32'h10000, 96'h0, 32'h10000, 96'h0, 32'h10000});
		send_matrix({9{32'h8000_0000}});
		send_matrix({9{32'h7FFF_FFFF}});
		send_matrix({9{32'hFFFF_FFFF}});
		send_matrix({32'h7FFF_FFFF, 96'h0, 32'h8000_0000, 96'h0, 32'h7FFF_FFFF});
		send_matrix({32'h8000_0000, 96'h0, 32'h8000_0000, 96'h0, 32'h8000_0000});
		for (int k = 0; k < 9; k++) begin
			d = '0;
			d[k*32 +: 32] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			send_matrix(d);
		end
		send_matrix(288'({5{64'h5555_5555_AAAA_AAAA}}));
		send_matrix(288'({5{64'hAAAA_AAAA_5555_5555}}));
		for (int k = 0; k < 4; k++) send_random(4);

		// Zero moduli, then maximum, then smallest nonzero mu and lambda
		set_moduli('0, '0, '0);
		for (int k = 0; k < 20; k++) send_random(4);
		set_moduli('1, '1, '1);
		for (int k = 0; k < 30; k++) send_random(k % 2 ? 4 : 2);
		set_moduli(31'd1, 31'd1, 31'd65536);
		for (int k = 0; k < 30; k++) send_random(4);

		// Long hold-off while the sender keeps offering
		hold_off = 1;
		fork
			begin
				for (int k = 0; k < 40; k++) send_random(4);
			end
			begin
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
		join

		// Random moduli phases with mostly realistic matrices
		for (int ph = 0; ph < 5; ph++) begin
			set_moduli(coef_t'($urandom),
				coef_t'($urandom_range(0, 1) ? $urandom : $urandom_range(1, 1 << 20)),
				coef_t'($urandom));
			no_idle = (ph == 2);
			for (int k = 0; k < 60; k++) send_random($urandom_range(0, 3) != 0 ? 4 : 3);
		end
		no_idle = 0;
		set_moduli(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom));
		for (int k = 0; k < 20; k++) send_random(5);

		drain();
		if (fail_count == 0) begin
			$display("neo_hookean_energy_and_stress_unit_tb: done, clean");
		end else begin
			$display("neo_hookean_energy_and_stress_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
